[sv/windowed_histogram_normalize_unit_defines.svh]
// Assertion macros for the windowed histogram normalize unit.
// Depends on nothing; included by the checker module.
`ifndef WINDOWED_HISTOGRAM_NORMALIZE_UNIT_DEFINES_SVH
`define WINDOWED_HISTOGRAM_NORMALIZE_UNIT_DEFINES_SVH

// same-cycle implication
`define WHN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WHN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/whn_pkg.sv]
// Shared types and constants for the windowed histogram normalize unit.
// No dependencies.
package whn_pkg;

    localparam int MAX_BINS    = 64;
    localparam int COUNT_BITS  = 20;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int BCNT_W      = BIN_W + 1;
    localparam int STRIDE_W    = 13;
    localparam int PHASE_W     = 12;
    localparam int STRIDE_MAX  = 4096;
    localparam int FRAC_W      = 16;
    localparam int LOG_E_W     = $clog2(COUNT_BITS + 1);
    localparam int F_W         = (LOG_E_W + FRAC_W > COUNT_BITS) ?
                                 (LOG_E_W + FRAC_W) : COUNT_BITS;
    localparam int M_W         = 31;
    localparam int DIV_W       = 48;
    localparam int QUO_W       = 16;
    localparam int STEP_W      = 5;
    localparam int NORM_STEPS  = 16;
    localparam int NORM_SCALE  = 65535;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_WLOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WHIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BINS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOG    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE = 3'd4;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               sample_finite;
        logic               last_sample;
    } hist_in_t;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [15:0] bin_value;
        logic        last_bin;
    } hist_out_t;

    typedef struct packed {
        logic signed [31:0]  window_low;
        logic signed [31:0]  window_high;
        logic [6:0]          bin_count;
        logic                log_scale;
        logic [STRIDE_W-1:0] sample_stride;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_BINIT, S_BDIV, S_BRD, S_BWR,
        S_EINIT, S_ERD, S_EF, S_ELOG, S_EWR,
        S_NINIT, S_NRD, S_NDI, S_NDIV, S_NOUT
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_bin;
        logic div_norm;
        logic div_step;
        logic brd;
        logic bwr;
        logic e_init;
        logic erd;
        logic log_init;
        logic log_step;
        logic ewr;
        logic n_init;
        logic nrd;
        logic n_next;
    } cmd_t;

    typedef struct packed {
        logic count_ok;
        logic last;
        logic div_done;
        logic log_done;
        logic log_on;
        logic k_last;
    } sts_t;

endpackage

[sv/whn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module whn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/whn_regs.sv]
// APB configuration registers.
// Depends on whn_pkg.
module whn_regs
    import whn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low    <= 32'sd0;
            cfg_reg.window_high   <= 32'sd65536;
            cfg_reg.bin_count     <= 7'd64;
            cfg_reg.log_scale     <= 1'b0;
            cfg_reg.sample_stride <= 13'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WLOW:   cfg_reg.window_low    <= pwdata;
                REG_WHIGH:  cfg_reg.window_high   <= pwdata;
                REG_BINS:   cfg_reg.bin_count     <= pwdata[6:0];
                REG_LOG:    cfg_reg.log_scale     <= pwdata[0];
                REG_STRIDE: cfg_reg.sample_stride <= pwdata[STRIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WLOW:   prdata = cfg_reg.window_low;
            REG_WHIGH:  prdata = cfg_reg.window_high;
            REG_BINS:   prdata = {25'd0, cfg_reg.bin_count};
            REG_LOG:    prdata = {31'd0, cfg_reg.log_scale};
            REG_STRIDE: prdata = {19'd0, cfg_reg.sample_stride};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

[sv/whn_ctrl.sv]
// Sequencer for binning, log/max pass and normalize pass.
// Depends on whn_pkg.
module whn_ctrl
    import whn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic strobe
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_PREP;
            S_PREP:  state_next = S_BINIT;
            S_BINIT:
            begin
                if (sts.count_ok)  state_next = S_BDIV;
                else if (sts.last) state_next = S_EINIT;
                else               state_next = S_IDLE;
            end
            S_BDIV:  if (sts.div_done) state_next = S_BRD;
            S_BRD:   state_next = S_BWR;
            S_BWR:   state_next = sts.last ? S_EINIT : S_IDLE;
            S_EINIT: state_next = S_ERD;
            S_ERD:   state_next = S_EF;
            S_EF:    state_next = sts.log_on ? S_ELOG : S_EWR;
            S_ELOG:  if (sts.log_done) state_next = S_EWR;
            S_EWR:   state_next = sts.k_last ? S_NINIT : S_ERD;
            S_NINIT: state_next = S_NRD;
            S_NRD:   state_next = S_NDI;
            S_NDI:   state_next = S_NDIV;
            S_NDIV:  if (sts.div_done) state_next = S_NOUT;
            S_NOUT:  state_next = sts.k_last ? S_IDLE : S_NRD;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd    = '0;
        busy   = 1'b1;
        strobe = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_PREP:  cmd.prep     = 1'b1;
            S_BINIT: cmd.div_bin  = 1'b1;
            S_BDIV:  cmd.div_step = !sts.div_done;
            S_BRD:   cmd.brd      = 1'b1;
            S_BWR:   cmd.bwr      = 1'b1;
            S_EINIT: cmd.e_init   = 1'b1;
            S_ERD:   cmd.erd      = 1'b1;
            S_EF:    cmd.log_init = 1'b1;
            S_ELOG:  cmd.log_step = !sts.log_done;
            S_EWR:   cmd.ewr      = 1'b1;
            S_NINIT: cmd.n_init   = 1'b1;
            S_NRD:   cmd.nrd      = 1'b1;
            S_NDI:   cmd.div_norm = 1'b1;
            S_NDIV:  cmd.div_step = !sts.div_done;
            S_NOUT:
            begin
                strobe     = 1'b1;
                cmd.n_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[sv/whn_dp.sv]
// Datapath: stride, bin index divide, counters, log2 unit, max and normalize.
// Depends on whn_pkg and whn_ram.
module whn_dp
    import whn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  hist_in_t  item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output hist_out_t result
);

    // input beat
    logic signed [31:0] sample_reg;
    logic               finite_reg;
    logic               last_reg;
    logic               use_reg;
    logic [PHASE_W-1:0] phase_reg;

    // binning
    logic [DIV_W-1:0]   num_reg;
    logic               ok_reg;

    // shared restoring divider
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dsh_reg;
    logic [QUO_W-1:0]   q_reg;
    logic [STEP_W-1:0]  cnt_reg;

    // emission
    logic [BIN_W-1:0]   k_reg;
    logic [F_W-1:0]     mx_reg;
    logic [F_W-1:0]     f_reg;
    logic [LOG_E_W-1:0] e_reg;
    logic [M_W-1:0]     m_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [STEP_W-1:0]  lcnt_reg;

    logic [MAX_BINS-1:0] valid_reg;
    logic                vrd_reg;

    // config decode
    logic [BCNT_W-1:0]   n_use;
    logic [BIN_W-1:0]    nm1;
    logic [STRIDE_W-1:0] stride_use;
    logic [STRIDE_W-1:0] phase_inc;
    logic signed [32:0]  span_s;
    logic [31:0]         span;
    logic signed [32:0]  d_s;
    logic                in_win;
    logic [31+BIN_W:0]   prod;

    logic [BIN_W-1:0]      bin_sel;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [COUNT_BITS-1:0] cnt_val;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [BIN_W-1:0]      craddr;
    logic [F_W-1:0]        f_rd;
    logic [F_W-1:0]        f_cur;

    logic [COUNT_BITS:0]   lx;
    logic [LOG_E_W-1:0]    le;
    logic [63:0]           lxw;
    logic [M_W-1:0]        lm;
    logic [2*M_W-1:0]      sq;
    logic [M_W:0]          sq_sh;

    logic [F_W+FRAC_W-1:0] nprod;
    logic [DIV_W-1:0]      rem_sub;
    logic                  rem_ge;

    always_comb
    begin
        if (cfg.bin_count == '0)
            n_use = BCNT_W'(1);
        else if (cfg.bin_count > BCNT_W'(MAX_BINS))
            n_use = BCNT_W'(MAX_BINS);
        else
            n_use = cfg.bin_count[BCNT_W-1:0];
        nm1 = BIN_W'(n_use - BCNT_W'(1));

        if (cfg.sample_stride == '0)
            stride_use = STRIDE_W'(1);
        else if (cfg.sample_stride > STRIDE_W'(STRIDE_MAX))
            stride_use = STRIDE_W'(STRIDE_MAX);
        else
            stride_use = cfg.sample_stride;
        phase_inc = {1'b0, phase_reg} + STRIDE_W'(1);

        span_s = {cfg.window_high[31], cfg.window_high} - {cfg.window_low[31], cfg.window_low};
        span   = (span_s < 33'sd1) ? 32'd1 : span_s[31:0];
        d_s    = {sample_reg[31], sample_reg} - {cfg.window_low[31], cfg.window_low};
        in_win = !d_s[32] && (d_s[31:0] <= span);
        prod   = {{BIN_W{1'b0}}, d_s[31:0]} * {32'd0, nm1};
    end

    assign bin_sel = (q_reg > QUO_W'(nm1)) ? nm1 : q_reg[BIN_W-1:0];
    assign craddr  = cmd.brd ? bin_sel : k_reg;
    assign cnt_val = vrd_reg ? cnt_rd : '0;
    assign cnt_inc = (cnt_val == {COUNT_BITS{1'b1}}) ? cnt_val : cnt_val + COUNT_BITS'(1);

    whn_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.bwr),
        .waddr (bin_sel),
        .wdata (cnt_inc),
        .raddr (craddr),
        .rdata (cnt_rd)
    );

    assign f_cur = cfg.log_scale ? F_W'({e_reg, frac_reg}) : f_reg;

    whn_ram #(.WIDTH(F_W), .DEPTH(MAX_BINS)) u_f_ram (
        .clk   (clk),
        .we    (cmd.ewr),
        .waddr (k_reg),
        .wdata (f_cur),
        .raddr (k_reg),
        .rdata (f_rd)
    );

    // log2 front end: leading one and mantissa alignment
    always_comb
    begin
        lx = {1'b0, cnt_val} + (COUNT_BITS+1)'(1);
        le = '0;
        for (int i = 0; i <= COUNT_BITS; i++)
        begin
            if (lx[i]) le = LOG_E_W'(i);
        end
        lxw = 64'(lx);
        if (le <= LOG_E_W'(M_W - 1))
            lm = M_W'(lxw << (LOG_E_W'(M_W - 1) - le));
        else
            lm = M_W'(lxw >> (le - LOG_E_W'(M_W - 1)));
    end

    assign sq    = m_reg * m_reg;
    assign sq_sh = sq[2*M_W-1:M_W-1];

    assign nprod   = f_rd * FRAC_W'(NORM_SCALE);
    assign rem_ge  = rem_reg >= dsh_reg;
    assign rem_sub = rem_reg - dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= '0;
            cnt_reg   <= '0;
            lcnt_reg  <= '0;
            k_reg     <= '0;
            ok_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg <= (phase_inc >= stride_use) ? '0 : phase_inc[PHASE_W-1:0];
            end
            if (cmd.prep)
            begin
                ok_reg <= use_reg && finite_reg && in_win;
            end
            if (cmd.load)
            begin
                last_reg <= item.last_sample;
            end
            if (cmd.bwr)
            begin
                valid_reg[bin_sel] <= 1'b1;
            end
            if (cmd.div_bin)
            begin
                cnt_reg <= STEP_W'(BIN_W);
            end
            else if (cmd.div_norm)
            begin
                cnt_reg <= STEP_W'(NORM_STEPS);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
            if (cmd.log_init)
            begin
                lcnt_reg <= STEP_W'(FRAC_W);
            end
            else if (cmd.log_step)
            begin
                lcnt_reg <= lcnt_reg - STEP_W'(1);
            end
            if (cmd.e_init || cmd.n_init)
            begin
                k_reg <= '0;
            end
            else if ((cmd.ewr || cmd.n_next) && (k_reg != nm1))
            begin
                k_reg <= k_reg + BIN_W'(1);
            end
            if (cmd.n_next && (k_reg == nm1))
            begin
                valid_reg <= '0;
                phase_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= item.sample;
            finite_reg <= item.sample_finite;
            use_reg    <= (phase_reg == '0);
        end
        if (cmd.prep)
        begin
            num_reg <= DIV_W'(prod);
        end
        vrd_reg <= valid_reg[craddr];
        if (cmd.div_bin)
        begin
            rem_reg <= num_reg;
            dsh_reg <= DIV_W'(span) << (BIN_W - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_norm)
        begin
            rem_reg <= DIV_W'(nprod) + DIV_W'(mx_reg >> 1);
            dsh_reg <= DIV_W'(mx_reg) << (NORM_STEPS - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sub;
            end
            q_reg   <= {q_reg[QUO_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.log_init)
        begin
            f_reg    <= F_W'(cnt_val);
            e_reg    <= le;
            m_reg    <= lm;
            frac_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            frac_reg <= {frac_reg[FRAC_W-2:0], sq_sh[M_W]};
            m_reg    <= sq_sh[M_W] ? sq_sh[M_W:1] : sq_sh[M_W-1:0];
        end
        if (cmd.e_init)
        begin
            mx_reg <= '0;
        end
        else if (cmd.ewr && (f_cur > mx_reg))
        begin
            mx_reg <= f_cur;
        end
    end

    assign sts.count_ok = ok_reg;
    assign sts.last     = last_reg;
    assign sts.div_done = (cnt_reg == '0);
    assign sts.log_done = (lcnt_reg == '0);
    assign sts.log_on   = cfg.log_scale;
    assign sts.k_last   = (k_reg == nm1);

    assign result.bin_index = 6'(k_reg);
    assign result.bin_value = (mx_reg == '0) ? 16'd0 : q_reg;
    assign result.last_bin  = (k_reg == nm1);

endmodule

[sv/windowed_histogram_normalize_unit.sv]
// Windowed histogram normalize unit, top level.
// Each accepted sample keeps busy high; a counted one also runs the 6-step bin divide.
// On the last sample: each bin is read and written (with log2, after 16 squaring steps), then
// each result takes a 16-step normalize divide; results leave one per strobe.
// rst_n is asynchronous: counters read zero, registers return to defaults.
// Depends on whn_pkg, whn_regs, whn_ctrl, whn_dp, whn_ram.
module windowed_histogram_normalize_unit
    import whn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    input  hist_in_t          item,
    output logic              busy,
    output logic              strobe,
    output hist_out_t         result
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    whn_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    whn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    whn_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

[sv/whn_checker.sv]
// Port-level checks on the windowed histogram normalize unit, bound to the top.
// Depends on whn_pkg and windowed_histogram_normalize_unit_defines.svh.
`include "windowed_histogram_normalize_unit_defines.svh"

module whn_checker
    import whn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      strobe,
    input hist_out_t result
);

    `WHN_ASSERT_NOW(a_strobe_busy, strobe, busy, "result beat while not busy")
    `WHN_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat left block idle")
    `WHN_ASSERT_NXT(a_strobe_gap, strobe, !strobe, "back-to-back result beats")
    `WHN_ASSERT_NXT(a_last_idle, strobe && result.last_bin, !busy, "busy after final bin")

endmodule

bind windowed_histogram_normalize_unit whn_checker u_whn_checker (.*);

[bench/testbench.sv]
// Self-checking bench for windowed_histogram_normalize_unit: directed table, then random images.
// Expected bins come from an in-bench histogram/normalize predictor; depends on whn_pkg and the RTL.
module testbench;
    import whn_pkg::*;

    localparam int LIMIT = 2000000;

    typedef struct {
        bit                   is_cfg;
        logic [REG_IDX_W-1:0] reg_sel;
        logic [31:0]          data;
        hist_in_t             beat;
        bit                   fixed;
        logic [15:0]          fixed_val;
    } step_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    hist_in_t          item = '0;
    logic              busy;
    logic              strobe;
    hist_out_t         result;

    logic signed [31:0]  win_low = 32'sd0;
    logic signed [31:0]  win_high = 32'sd65536;
    logic [6:0]          bins_reg = 7'd64;
    logic                log_on = 1'b0;
    logic [STRIDE_W-1:0] stride_reg = 13'd1;
    logic [COUNT_BITS-1:0] hist [MAX_BINS];
    logic [PHASE_W-1:0]  phase = '0;

    hist_out_t bins_due [$];
    step_t     table_q [$];
    int        errors = 0;
    int        cycles = 0;
    int        idle_pct = 0;

    windowed_histogram_normalize_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .item(item), .busy(busy), .strobe(strobe), .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        hist_out_t want;
        if (rst_n && strobe)
        begin
            if (bins_due.size() == 0)
                report("unexpected bin", 0, result.bin_index);
            else
            begin
                want = bins_due.pop_front();
                if (result.bin_index !== want.bin_index)
                    report("bin_index", want.bin_index, result.bin_index);
                if (result.bin_value !== want.bin_value)
                    report("bin_value", want.bin_value, result.bin_value);
                if (result.last_bin !== want.last_bin)
                    report("last_bin", want.last_bin, result.last_bin);
            end
        end
    end

    function automatic int active_bins();
        if (bins_reg == 0)
            return 1;
        if (bins_reg > MAX_BINS)
            return MAX_BINS;
        return bins_reg;
    endfunction

    function automatic longint unsigned log2_q16(input longint unsigned c);
        longint unsigned x;
        longint unsigned m;
        longint unsigned frac;
        int e;
        x = c + 1;
        e = 0;
        frac = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31))
            begin
                frac |= 1;
                m >>= 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    // histogram update for one accepted beat; queues the bins it releases
    task automatic predict_bins(input hist_in_t b, input bit fixed, input logic [15:0] fval);
        int n;
        int stride;
        bit used;
        longint span;
        longint d;
        longint unsigned bin;
        longint unsigned f [MAX_BINS];
        longint unsigned mx;
        longint unsigned val;
        hist_out_t o;
        n = active_bins();
        stride = (stride_reg == 0) ? 1 : (stride_reg > STRIDE_MAX) ? STRIDE_MAX : stride_reg;
        used = (phase == 0);
        phase = ((int'(phase) + 1) >= stride) ? '0 : phase + 1'b1;
        if (used && b.sample_finite)
        begin
            span = longint'(win_high) - longint'(win_low);
            d = longint'(b.sample) - longint'(win_low);
            if (span < 1)
                span = 1;
            if (d >= 0 && d <= span)
            begin
                bin = (longint'(d) * (n - 1)) / span;
                if (bin >= n)
                    bin = n - 1;
                if (hist[bin] != {COUNT_BITS{1'b1}})
                    hist[bin] = hist[bin] + 1'b1;
            end
        end
        if (!b.last_sample)
            return;
        mx = 0;
        for (int k = 0; k < n; k++)
        begin
            f[k] = log_on ? log2_q16(hist[k]) : hist[k];
            if (f[k] > mx)
                mx = f[k];
        end
        for (int k = 0; k < n; k++)
        begin
            val = 0;
            if (mx > 0)
            begin
                val = (f[k] * NORM_SCALE + mx / 2) / mx;
                if (val > NORM_SCALE)
                    val = NORM_SCALE;
            end
            o.bin_index = k[5:0];
            o.bin_value = fixed ? fval : val[15:0];
            o.last_bin = (k == n - 1);
            bins_due = {bins_due, o};
        end
        for (int k = 0; k < MAX_BINS; k++)
            hist[k] = '0;
        phase = '0;
    endtask

    task automatic send_beat(input hist_in_t b, input bit fixed, input logic [15:0] fval);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_bins(b, fixed, fval);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] sel, input logic [31:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (bins_due.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_WLOW:   win_low = v;
            REG_WHIGH:  win_high = v;
            REG_BINS:   bins_reg = v[6:0];
            REG_LOG:    log_on = v[0];
            REG_STRIDE: stride_reg = v[STRIDE_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic add_row(input step_t s);
        table_q = {table_q, s};
    endtask

    function automatic step_t cfg_row(input logic [REG_IDX_W-1:0] sel, input logic [31:0] v);
        step_t s;
        s = '{1'b1, sel, v, '0, 1'b0, 16'd0};
        return s;
    endfunction

    function automatic step_t beat_row(input logic [31:0] v, input bit fin, input bit last);
        step_t s;
        s = '{1'b0, REG_WLOW, 32'd0, '{v, fin, last}, 1'b0, 16'd0};
        return s;
    endfunction

    function automatic step_t fixed_row(input logic [31:0] v, input logic [15:0] fv);
        step_t s;
        s = '{1'b0, REG_WLOW, 32'd0, '{v, 1'b1, 1'b1}, 1'b1, fv};
        return s;
    endfunction

    initial
    begin
        hist_in_t b;
        longint range;
        int sent;
        int len;
        for (int k = 0; k < MAX_BINS; k++)
            hist[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty image: every bin zero; single bin holding all counts: full scale
        add_row(fixed_row(32'h8000_0000, 16'd0));
        add_row(cfg_row(REG_BINS, 32'd1));
        add_row(beat_row(32'd0, 1'b1, 1'b0));
        add_row(fixed_row(32'd0, 16'd65535));
        add_row(cfg_row(REG_BINS, 32'd64));
        add_row(cfg_row(REG_LOG, 32'd1));
        add_row(beat_row(32'd65536, 1'b1, 1'b0));
        add_row(beat_row(32'd0, 1'b1, 1'b0));
        add_row(beat_row(32'hFFFF_FFFF, 1'b1, 1'b0));
        add_row(beat_row(32'd32768, 1'b0, 1'b0));
        add_row(beat_row(32'h7FFF_FFFF, 1'b1, 1'b1));
        add_row(cfg_row(REG_WLOW, 32'h8000_0000));
        add_row(cfg_row(REG_WHIGH, 32'h7FFF_FFFF));
        add_row(cfg_row(REG_STRIDE, 32'd10));
        add_row(beat_row(32'h8000_0000, 1'b1, 1'b0));
        add_row(beat_row(32'h1234_5678, 1'b1, 1'b0));
        add_row(beat_row(32'h0, 1'b1, 1'b0));
        // stride lowered below the running phase
        add_row(cfg_row(REG_STRIDE, 32'd2));
        add_row(beat_row(32'h7FFF_FFFF, 1'b1, 1'b0));
        add_row(beat_row(32'h7FFF_FFFF, 1'b1, 1'b1));
        // inverted window, bin count and stride out of range
        add_row(cfg_row(REG_WLOW, 32'd5));
        add_row(cfg_row(REG_WHIGH, 32'd3));
        add_row(cfg_row(REG_BINS, 32'd0));
        add_row(cfg_row(REG_STRIDE, 32'd0));
        add_row(beat_row(32'd5, 1'b1, 1'b0));
        add_row(beat_row(32'd6, 1'b1, 1'b1));
        add_row(cfg_row(REG_BINS, 32'd127));
        add_row(cfg_row(REG_STRIDE, 32'd8191));
        add_row(beat_row(32'd5, 1'b1, 1'b0));
        add_row(beat_row(32'd6, 1'b1, 1'b1));
        add_row(cfg_row(REG_LOG, 32'd0));
        add_row(beat_row(32'd6, 1'b1, 1'b0));
        add_row(beat_row(32'd5, 1'b1, 1'b1));

        foreach (table_q[i])
        begin
            if (table_q[i].is_cfg)
                write_reg(table_q[i].reg_sel, table_q[i].data);
            else
                send_beat(table_q[i].beat, table_q[i].fixed, table_q[i].fixed_val);
        end

        sent = 0;
        while (sent < 100)
        begin
            idle_pct = (sent < 25) ? 0 : (sent < 50) ? 80 : (sent < 75) ? 0 : 33;
            if ($urandom_range(1) == 0)
            begin
                write_reg(REG_WLOW, ($urandom_range(3) == 0) ? $urandom : $urandom_range(200));
                write_reg(REG_WHIGH, ($urandom_range(4) == 0) ? $urandom
                          : win_low + $urandom_range(300));
                write_reg(REG_BINS, ($urandom_range(5) == 0) ? 64 : $urandom_range(1, 8));
                write_reg(REG_LOG, $urandom_range(1));
                write_reg(REG_STRIDE, ($urandom_range(7) == 0) ? $urandom_range(8191)
                          : $urandom_range(1, 3));
            end
            len = $urandom_range(1, 10);
            range = longint'(win_high) - longint'(win_low);
            if (range < 0)
                range = 1;
            for (int i = 0; i < len; i++)
            begin
                b.sample = ($urandom_range(9) < 7) ? 32'(longint'(win_low)
                           + longint'({$urandom, $urandom} % (range + 1))) : $urandom;
                b.sample_finite = ($urandom_range(9) != 0);
                b.last_sample = (i == len - 1);
                send_beat(b, 1'b0, 16'd0);
                sent++;
            end
        end
        start <= 1'b0;
        @(posedge clk);
        while (bins_due.size() != 0 || busy)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[windowed_histogram_normalize_unit.f]
+incdir+sv
sv/whn_pkg.sv
sv/whn_ram.sv
sv/whn_regs.sv
sv/whn_ctrl.sv
sv/whn_dp.sv
sv/windowed_histogram_normalize_unit.sv
sv/whn_checker.sv
bench/testbench.sv
